[rtl/mpva_pkg.sv]
// mpva_pkg: shared types and constants for the midi parser / voice allocator
// holds parser and controller state encodings and the control/status structs
// no dependencies
`default_nettype none

package mpva_pkg;

  localparam int MaxVoicesDflt = 8;
  localparam logic [7:0] NoteOnRst = 8'd155;
  localparam logic [3:0] VoicesRst = 4'd4;

  // register byte addresses
  localparam logic [2:0] AddrNoteOn = 3'd0;
  localparam logic [2:0] AddrVoices = 3'd4;

  // midi status byte codes
  localparam logic [7:0] StSysex  = 8'hf0;
  localparam logic [7:0] StMtc    = 8'hf1;
  localparam logic [7:0] StSongPos = 8'hf2;
  localparam logic [7:0] StSongSel = 8'hf3;
  localparam logic [7:0] StCommonLast = 8'hf7;
  localparam logic [7:0] StOneFirst = 8'hc0;
  localparam logic [7:0] StOneLast  = 8'hdf;

  // message parser state, one-hot
  typedef enum logic [6:0] {
    PS_UNKNOWN    = 7'b0000001,
    PS_ONE        = 7'b0000010,
    PS_ONE_RUN    = 7'b0000100,
    PS_TWO_FIRST  = 7'b0001000,
    PS_TWO_SECOND = 7'b0010000,
    PS_TWO_RUN    = 7'b0100000,
    PS_SYSEX      = 7'b1000000
  } parse_state_e;

  // controller state, one-hot
  typedef enum logic [2:0] {
    CS_IDLE   = 3'b001,
    CS_SEARCH = 3'b010,
    CS_FINISH = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic accept;       // input byte transfer this cycle
    logic search_step;  // examine one voice slot
    logic commit;       // update slot and load output register
  } mpva_cmd_t;

  typedef struct packed {
    logic msg_done;     // current byte completes a two-data-byte message
    logic search_end;   // slot search has finished
    logic found;        // a slot change is due
    logic out_free;     // output register can take a result
  } mpva_sts_t;

endpackage

`default_nettype wire

[rtl/mpva_ctrl.sv]
// mpva_ctrl: controller state machine for the voice allocator
// sequences byte transfer, slot search and result commit
// depends on mpva_pkg
`default_nettype none

module mpva_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mpva_pkg::mpva_sts_t sts_i,
  output mpva_pkg::mpva_cmd_t     cmd_o
);

  mpva_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mpva_pkg::CS_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.msg_done) begin
          state_d = mpva_pkg::CS_SEARCH;
        end
      end
      mpva_pkg::CS_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.search_end) begin
          state_d = mpva_pkg::CS_FINISH;
        end
      end
      mpva_pkg::CS_FINISH: begin
        if (!sts_i.found) begin
          state_d = mpva_pkg::CS_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = mpva_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = mpva_pkg::CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpva_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/mpva_datapath.sv]
// mpva_datapath: midi parser registers, voice slot table and output register
// one slot examined per search step, result held until transferred
// depends on mpva_pkg
`default_nettype none

module mpva_datapath #(
  parameter int MAX_VOICES = mpva_pkg::MaxVoicesDflt
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mpva_pkg::mpva_cmd_t cmd_i,
  output mpva_pkg::mpva_sts_t     sts_o,
  input  wire logic [7:0]         midi_byte_i,
  input  wire logic [7:0]         note_on_status_i,
  input  wire logic [3:0]         voices_in_use_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              voice_slot_o,
  output logic [6:0]              key_number_o,
  output logic [14:0]             voice_level_o,
  output logic                    is_assign_o
);

  localparam int IdxW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CntW = $clog2(MAX_VOICES + 1);
  localparam int CmpW = (CntW > 4) ? CntW : 4;

  mpva_pkg::parse_state_e parse_q, parse_d;
  logic [7:0] last_status_q;
  logic [6:0] pend_key_q;
  logic [6:0] pend_vel_q;
  logic       is_on_q;

  logic [6:0] slot_key_q [MAX_VOICES];

  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] sel_q;
  logic            found_q;

  logic        out_valid_q;
  logic [2:0]  out_slot_q;
  logic [6:0]  out_key_q;
  logic [14:0] out_level_q;
  logic        out_assign_q;

  logic [CmpW-1:0] voices_ext;
  logic [CntW-1:0] n_slots;
  logic            at_end;
  logic [6:0]      cur_key;
  logic            hit_free;
  logic            hit_key;
  logic            is_data;

  // clamp the searched slot count to the table size
  assign voices_ext = CmpW'(voices_in_use_i);
  assign n_slots = (voices_ext > CmpW'(MAX_VOICES)) ? CntW'(MAX_VOICES) : CntW'(voices_ext);

  assign at_end   = (cnt_q == n_slots);
  assign cur_key  = at_end ? 7'd0 : slot_key_q[cnt_q[IdxW-1:0]];
  assign hit_free = (cur_key == 7'd0);
  assign hit_key  = (cur_key == pend_key_q);
  assign is_data  = !midi_byte_i[7];

  assign sts_o.msg_done   = is_data && (parse_q == mpva_pkg::PS_TWO_SECOND);
  assign sts_o.search_end = at_end || (is_on_q ? (!hit_free && hit_key) : hit_key);
  assign sts_o.found      = found_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // parser next state
  always_comb begin
    parse_d = parse_q;
    if (midi_byte_i >= mpva_pkg::StSysex) begin
      if (midi_byte_i == mpva_pkg::StSysex) begin
        parse_d = mpva_pkg::PS_SYSEX;
      end else if (midi_byte_i == mpva_pkg::StMtc || midi_byte_i == mpva_pkg::StSongSel) begin
        parse_d = mpva_pkg::PS_ONE;
      end else if (midi_byte_i == mpva_pkg::StSongPos) begin
        parse_d = mpva_pkg::PS_TWO_FIRST;
      end else if (midi_byte_i <= mpva_pkg::StCommonLast) begin
        parse_d = mpva_pkg::PS_UNKNOWN;
      end
    end else if (!is_data) begin
      if (midi_byte_i >= mpva_pkg::StOneFirst && midi_byte_i <= mpva_pkg::StOneLast) begin
        parse_d = mpva_pkg::PS_ONE;
      end else begin
        parse_d = mpva_pkg::PS_TWO_FIRST;
      end
    end else begin
      unique case (parse_q)
        mpva_pkg::PS_ONE:        parse_d = mpva_pkg::PS_ONE_RUN;
        mpva_pkg::PS_TWO_FIRST:  parse_d = mpva_pkg::PS_TWO_SECOND;
        mpva_pkg::PS_TWO_RUN:    parse_d = mpva_pkg::PS_TWO_SECOND;
        mpva_pkg::PS_TWO_SECOND: parse_d = mpva_pkg::PS_TWO_RUN;
        default:                 parse_d = parse_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q       <= mpva_pkg::PS_UNKNOWN;
      last_status_q <= 8'd0;
      pend_key_q    <= 7'd0;
      pend_vel_q    <= 7'd0;
      is_on_q       <= 1'b0;
    end else if (cmd_i.accept) begin
      parse_q <= parse_d;
      is_on_q <= (last_status_q == note_on_status_i);
      if (!is_data && midi_byte_i < mpva_pkg::StSysex
          && !(midi_byte_i >= mpva_pkg::StOneFirst && midi_byte_i <= mpva_pkg::StOneLast)) begin
        last_status_q <= midi_byte_i;
      end
      if (is_data && (parse_q == mpva_pkg::PS_TWO_FIRST || parse_q == mpva_pkg::PS_TWO_RUN)) begin
        pend_key_q <= midi_byte_i[6:0];
      end
      if (is_data && parse_q == mpva_pkg::PS_TWO_SECOND) begin
        pend_vel_q <= midi_byte_i[6:0];
      end
    end
  end

  // slot search: note-on keeps the last free slot unless the key is already held,
  // release takes the first slot holding the key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sel_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.accept) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.search_step && !at_end) begin
      cnt_q <= cnt_q + CntW'(1);
      if (is_on_q) begin
        if (hit_free) begin
          found_q <= 1'b1;
          sel_q   <= cnt_q[IdxW-1:0];
        end else if (hit_key) begin
          found_q <= 1'b0;
        end
      end else if (hit_key) begin
        found_q <= 1'b1;
        sel_q   <= cnt_q[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VOICES; i++) begin
        slot_key_q[i] <= 7'd0;
      end
    end else if (cmd_i.commit) begin
      slot_key_q[sel_q] <= is_on_q ? pend_key_q : 7'd0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_slot_q   <= 3'(sel_q);
      out_key_q    <= pend_key_q;
      out_level_q  <= is_on_q ? {pend_vel_q, 8'h00} : 15'd0;
      out_assign_q <= is_on_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign voice_slot_o  = out_slot_q;
  assign key_number_o  = out_key_q;
  assign voice_level_o = out_level_q;
  assign is_assign_o   = out_assign_q;

endmodule

`default_nettype wire

[rtl/midi_parser_voice_allocator.sv]
// midi_parser_voice_allocator: midi byte parser with polyphonic voice allocation
//
// input channel: one midi byte per transfer (in_valid_i / in_stall_o / midi_byte_i)
// output channel: one voice change per transfer (out_valid_o / out_stall_i and
//   voice_slot_o, key_number_o, voice_level_o, is_assign_o)
// config: apb-style port, note_on_status at byte address 0, voices_in_use at 4
//
// a byte that does not complete a two-data-byte message is taken with no stall, and
// the next byte can be taken in the following cycle
// a completing byte starts a slot search that walks one voice slot per cycle:
//   the byte is accepted, the search walks the slots up to n, with n the
//   voices_in_use value clamped to MAX_VOICES, and a commit step follows
// the slot walk over the key table sets the length of this sequence
// the result lands in an output register in the cycle after commit; a new byte
// may be taken while it waits
// if the receiver stalls with a result still pending, the next result holds in
// the commit cycle until the output register frees up
// reset clears the parser, all voice slots (free) and the output valid, and
// loads the config registers with their defaults; no clearing pass is needed
`default_nettype none

module midi_parser_voice_allocator #(
  parameter int MAX_VOICES = mpva_pkg::MaxVoicesDflt
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // apb-style config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  // midi byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  midi_byte_i,

  // voice change output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       voice_slot_o,
  output logic [6:0]       key_number_o,
  output logic [14:0]      voice_level_o,
  output logic             is_assign_o
);

  logic [7:0] note_on_q;
  logic [3:0] voices_q;
  logic       cfg_wr;

  mpva_pkg::mpva_cmd_t cmd;
  mpva_pkg::mpva_sts_t sts;

  // config registers, written in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_on_q <= mpva_pkg::NoteOnRst;
      voices_q  <= mpva_pkg::VoicesRst;
    end else if (cfg_wr) begin
      // register index from the word address bit
      if (paddr[2] == mpva_pkg::AddrNoteOn[2]) begin
        note_on_q <= pwdata[7:0];
      end else begin
        voices_q <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mpva_pkg::AddrVoices[2]) begin
      prdata = {28'd0, voices_q};
    end else begin
      prdata = {24'd0, note_on_q};
    end
  end

  // sequencer: byte transfer, slot walk, commit
  mpva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // parser, key table and output register
  mpva_datapath #(
    .MAX_VOICES (MAX_VOICES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .midi_byte_i      (midi_byte_i),
    .note_on_status_i (note_on_q),
    .voices_in_use_i  (voices_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .voice_slot_o     (voice_slot_o),
    .key_number_o     (key_number_o),
    .voice_level_o    (voice_level_o),
    .is_assign_o      (is_assign_o)
  );

endmodule

`default_nettype wire

[dv/mpva_voice_checker.sv]
// mpva_voice_checker: watches the midi byte, voice change and config channels of
// midi_parser_voice_allocator, predicts every voice change and compares it
// depends on mpva_pkg for parser states, status codes and register addresses
module mpva_voice_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  midi_byte_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [2:0]  voice_slot_o,
  input  logic [6:0]  key_number_o,
  input  logic [14:0] voice_level_o,
  input  logic        is_assign_o,
  output int          changes_pending_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpva_pkg::*;

  localparam int MaxSlots = MaxVoicesDflt;

  typedef struct packed {
    logic [2:0]  slot;
    logic [6:0]  key;
    logic [14:0] level;
    logic        is_assign;
  } voice_change_t;

  voice_change_t voice_changes_due [$];

  parse_state_e parser_st;
  logic [7:0]  note_on_reg;
  logic [3:0]  voices_reg;
  logic [7:0]  chan_status;
  logic [6:0]  key_latched;
  logic [6:0]  vel_latched;
  logic [6:0]  slot_key [MaxSlots];
  logic [14:0] slot_lvl [MaxSlots];

  initial begin
    changes_pending_o = 0;
    fail_count_o = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] voice change mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic clear_voices();
    parser_st = PS_UNKNOWN;
    note_on_reg = NoteOnRst;
    voices_reg = VoicesRst;
    chan_status = '0;
    key_latched = '0;
    vel_latched = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      slot_key[i] = '0;
      slot_lvl[i] = '0;
    end
  endtask

  // append one predicted voice change at the tail of the queue
  task automatic enqueue_change(input voice_change_t vc);
    voice_changes_due = {voice_changes_due, vc};
  endtask

  // message complete: allocate on note-on, otherwise release
  task automatic update_voices();
    int n;
    int free_idx;
    bit have_free;
    bit sounding;
    bit released;
    voice_change_t vc;
    n = (voices_reg > MaxSlots) ? MaxSlots : int'(voices_reg);
    if (chan_status == note_on_reg) begin
      have_free = 1'b0;
      sounding = 1'b0;
      free_idx = 0;
      for (int i = 0; i < n && !sounding; i++) begin
        if (slot_key[i] == '0) begin
          have_free = 1'b1;
          free_idx = i;
        end else if (slot_key[i] == key_latched) begin
          sounding = 1'b1;
        end
      end
      if (have_free && !sounding) begin
        slot_key[free_idx] = key_latched;
        slot_lvl[free_idx] = {vel_latched, 8'h00};
        vc.slot = free_idx[2:0];
        vc.key = key_latched;
        vc.level = slot_lvl[free_idx];
        vc.is_assign = 1'b1;
        enqueue_change(vc);
      end
    end else begin
      released = 1'b0;
      for (int i = 0; i < n && !released; i++) begin
        if (slot_key[i] == key_latched) begin
          slot_key[i] = '0;
          slot_lvl[i] = '0;
          vc.slot = i[2:0];
          vc.key = key_latched;
          vc.level = '0;
          vc.is_assign = 1'b0;
          enqueue_change(vc);
          released = 1'b1;
        end
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    if (b >= StSysex) begin
      // realtime bytes fall through and leave the parser alone
      if (b == StSysex) parser_st = PS_SYSEX;
      else if (b == StMtc || b == StSongSel) parser_st = PS_ONE;
      else if (b == StSongPos) parser_st = PS_TWO_FIRST;
      else if (b <= StCommonLast) parser_st = PS_UNKNOWN;
    end else if (b[7]) begin
      if (b >= StOneFirst && b <= StOneLast) begin
        parser_st = PS_ONE;
      end else begin
        parser_st = PS_TWO_FIRST;
        chan_status = b;
      end
    end else begin
      case (parser_st)
        PS_ONE: parser_st = PS_ONE_RUN;
        PS_TWO_FIRST, PS_TWO_RUN: begin
          key_latched = b[6:0];
          parser_st = PS_TWO_SECOND;
        end
        PS_TWO_SECOND: begin
          vel_latched = b[6:0];
          parser_st = PS_TWO_RUN;
          update_voices();
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_change(input voice_change_t got);
    voice_change_t want;
    if (voice_changes_due.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer slot %0d key %0d", got.slot, got.key));
    end else begin
      want = voice_changes_due.pop_front();
      if (got.slot !== want.slot)
        report_mismatch($sformatf("voice_slot %0d, want %0d", got.slot, want.slot));
      if (got.key !== want.key)
        report_mismatch($sformatf("key_number %0d, want %0d", got.key, want.key));
      if (got.level !== want.level)
        report_mismatch($sformatf("voice_level %0d, want %0d", got.level, want.level));
      if (got.is_assign !== want.is_assign)
        report_mismatch($sformatf("is_assign %0b, want %0b", got.is_assign, want.is_assign));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_voices();
      voice_changes_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrNoteOn) note_on_reg = pwdata[7:0];
        else if (paddr == AddrVoices) voices_reg = pwdata[3:0];
      end
      if (in_valid_i && !in_stall_o) parse_byte(midi_byte_i);
      if (out_valid_o && !out_stall_i)
        check_change({voice_slot_o, key_number_o, voice_level_o, is_assign_o});
    end
    changes_pending_o = voice_changes_due.size();
  end

endmodule

[dv/tb_midi_parser_voice_allocator.sv]
// tb_midi_parser_voice_allocator: stimulus and verdict for the midi parser /
// voice allocator; prediction and comparison live in mpva_voice_checker
// depends on mpva_pkg, midi_parser_voice_allocator and mpva_voice_checker
module tb_midi_parser_voice_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import mpva_pkg::*;

  // channel status codes used to build messages
  localparam logic [7:0] StNoteOff  = 8'h80;
  localparam logic [7:0] StNoteOn   = 8'h90;
  localparam logic [7:0] StPolyAt   = 8'ha0;
  localparam logic [7:0] StCtrl     = 8'hb0;
  localparam logic [7:0] StPitch    = 8'he0;
  localparam logic [7:0] StRealtime = 8'hf8;
  localparam logic [7:0] StLast     = 8'hff;

  localparam int NumPhases    = 8;
  localparam int PhaseBytes   = 130;
  localparam int SettleCycles = 32;   // longest slot search plus margin
  localparam int HoldOffCycles = 300;
  localparam longint RunLimitNs = 64'd10_000_000;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_TWO_OF_THREE,
    STALL_SPARSE
  } stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  midi_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  voice_slot_o;
  logic [6:0]  key_number_o;
  logic [14:0] voice_level_o;
  logic        is_assign_o;

  int changes_pending;
  int fail_count;

  // sender bookkeeping
  int   burst_left = 0;
  int   phase_bytes;
  bit   steady_send = 1'b0;   // no gaps while the receiver is held off
  bit   hold_off_req = 1'b0;  // asks the receiver for one long stall
  logic [7:0] cur_note_on = NoteOnRst;

  // register settings per phase; phase 0 keeps the reset values
  logic [7:0] phase_note_on [NumPhases] =
    '{NoteOnRst, 8'h90, 8'h80, 8'hef, 8'hc5, 8'h9f, 8'h95, 8'h80};
  logic [3:0] phase_voices [NumPhases] =
    '{VoicesRst, 4'd8, 4'd1, 4'd0, 4'd5, 4'd15, 4'd3, 4'd8};

  // opening sequence at reset settings (note-on 9B, four slots)
  logic [7:0] opening_seq [31];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  midi_parser_voice_allocator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .midi_byte_i  (midi_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .voice_slot_o (voice_slot_o),
    .key_number_o (key_number_o),
    .voice_level_o(voice_level_o),
    .is_assign_o  (is_assign_o)
  );

  mpva_voice_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .midi_byte_i      (midi_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .voice_slot_o     (voice_slot_o),
    .key_number_o     (key_number_o),
    .voice_level_o    (voice_level_o),
    .is_assign_o      (is_assign_o),
    .changes_pending_o(changes_pending),
    .fail_count_o     (fail_count)
  );

  // mostly a small key pool so that note-offs hit held notes and slots fill up
  function automatic logic [6:0] pick_key();
    if ($urandom_range(0, 9) < 7) return 7'($urandom_range(0, 9));
    return 7'($urandom_range(0, 127));
  endfunction

  // any two-data-byte channel status that is not the note-on one
  function automatic logic [7:0] pick_release_status();
    logic [7:0] kinds [5];
    logic [7:0] s;
    kinds = '{StNoteOff, StNoteOn, StPolyAt, StCtrl, StPitch};
    do
      s = kinds[$urandom_range(0, 4)] | 8'($urandom_range(0, 15));
    while (s == cur_note_on);
    return s;
  endfunction

  // one byte transfer; bursts of random length with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0 && !steady_send) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    midi_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    phase_bytes++;
  endtask

  // sender stops until every predicted voice change has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (changes_pending != 0);
    // a completing byte with no result may still be walking the slots
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // a setup phase and an access phase, then the bus goes idle
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_message();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // note-on, status sent or taken from running status
      if ($urandom_range(0, 2) != 0) send_byte(cur_note_on);
      send_byte({1'b0, pick_key()});
      if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(StRealtime, StLast)));
      send_byte({1'b0, 7'($urandom_range(0, 127))});
    end else if (kind < 75) begin
      // release through some other channel status
      if ($urandom_range(0, 2) != 0) send_byte(pick_release_status());
      send_byte({1'b0, pick_key()});
      send_byte({1'b0, 7'($urandom_range(0, 127))});
    end else if (kind < 88) begin
      case ($urandom_range(0, 4))
        0: begin
          send_byte($urandom_range(0, 1) ? StMtc : StSongSel);
          send_byte({1'b0, 7'($urandom_range(0, 127))});
        end
        1: begin
          // song position completes with the last stored channel status
          send_byte(StSongPos);
          send_byte({1'b0, pick_key()});
          send_byte({1'b0, 7'($urandom_range(0, 127))});
        end
        2: begin
          send_byte(StSysex);
          n = $urandom_range(0, 4);
          repeat (n) send_byte({1'b0, 7'($urandom_range(0, 127))});
        end
        3: begin
          send_byte(8'($urandom_range(StSongSel + 1, StCommonLast)));
          send_byte({1'b0, pick_key()});
        end
        default: begin
          send_byte(8'($urandom_range(StOneFirst, StOneLast)));
          n = $urandom_range(1, 3);
          repeat (n) send_byte({1'b0, 7'($urandom_range(0, 127))});
        end
      endcase
    end else begin
      // noise: any byte value
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: stall pattern rotates through the stall modes by cycle count, plus one long hold-off
  initial begin
    int cyc;
    stall_mode_e mode;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        mode = stall_mode_e'((cyc / 200) % 4);
        case (mode)
          STALL_NONE:         out_stall_i <= 1'b0;
          STALL_COIN:         out_stall_i <= ($urandom_range(0, 1) == 1);
          STALL_TWO_OF_THREE: out_stall_i <= (cyc % 3 != 0);
          default:            out_stall_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // main stimulus
  initial begin
    opening_seq = '{
      NoteOnRst, 8'h3c, 8'h64,      // note-on goes to highest free slot
      8'h3d, 8'h7f,                 // running status, top velocity
      8'h3c, 8'h10,                 // note already sounding, no change
      8'h00, StRealtime, 8'h00,     // key zero, velocity zero, realtime inside
      StSysex, 8'h3c, 8'h11,        // sysex data ignored
      StMtc, 8'h05,
      StOneFirst, 8'h10, 8'h11,     // one-data channel message, running
      StCommonLast, 8'h3d,          // undefined common status, data ignored
      StSongPos, 8'h3d, 8'h00,      // acts with stored note-on, already held
      StPitch, 8'h3c, 8'h00,        // release of a held note
      8'h00, 8'h00,                 // release of key zero takes a free slot
      StOneLast, 8'h7f,
      StLast
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    phase_bytes = 0;
    foreach (opening_seq[i]) send_byte(opening_seq[i]);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        wait_drained();
        apb_write(AddrNoteOn, 32'(phase_note_on[ph]));
        apb_write(AddrVoices, 32'(phase_voices[ph]));
        cur_note_on = phase_note_on[ph];
      end
      phase_bytes = 0;

      // receiver held off while the sender keeps offering transfers
      if (ph == 1) begin
        hold_off_req = 1'b1;
        steady_send = 1'b1;
        while (phase_bytes < 60) send_random_message();
        steady_send = 1'b0;
      end

      while (phase_bytes < PhaseBytes) begin
        send_random_message();
        if ($urandom_range(0, 40) == 0) wait_drained();
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_midi_parser_voice_allocator OK");
    end else begin
      $display("tb_midi_parser_voice_allocator NOT OK");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #(RunLimitNs);
    $display("tb_midi_parser_voice_allocator NOT OK");
    $finish;
  end

endmodule
